// ----- design/crm_pkg.sv -----
// Shared types and constants for the conference ring mixer.
// Field widths, request codes and member kinds; no dependencies.
`default_nettype none

package crm_pkg;

  localparam int FUNC_W   = 2;
  localparam int SLOT_W   = 3;
  localparam int SAMPLE_W = 16;
  localparam int FRAME_W  = 11;
  localparam int POS_W    = 10;
  localparam int KIND_W   = 2;
  localparam int COUNT_W  = 3;

  // Slots addressable by the 3-bit slot field.
  localparam int MAX_SLOTS = 1 << SLOT_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_MIX    = 2'd1,
    FUNC_STATUS = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  localparam logic [KIND_W-1:0] KIND_CONSULTANT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MASTER     = 2'd2;

endpackage

`default_nettype wire

// ----- design/crm_ring_mem.sv -----
// Sample ring store: one write port, one read port, registered read data.
// Depends on crm_pkg for the sample width.
`default_nettype none

module crm_ring_mem
  import crm_pkg::*;
#(
  parameter int ADDR_W = 13
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [ADDR_W-1:0]   waddr,
  input  wire logic [SAMPLE_W-1:0] wdata,
  input  wire logic                re,
  input  wire logic [ADDR_W-1:0]   raddr,
  output logic      [SAMPLE_W-1:0] rdata
);

  logic [SAMPLE_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/crm_mod_unit.sv -----
// Reduction of frame length and position modulo the ring depth.
// Reciprocal multiply, then multiply back and subtract, each step registered. Depends on crm_pkg.
`default_nettype none

module crm_mod_unit
  import crm_pkg::*;
#(
  parameter int RING_DEPTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [FRAME_W-1:0]            frame_length,
  input  wire logic [POS_W-1:0]              position,
  output logic                               done,
  output logic [$clog2(RING_DEPTH)-1:0]      back,
  output logic [$clog2(RING_DEPTH)-1:0]      fwd
);

  localparam int IW = $clog2(RING_DEPTH);
  localparam int RW = FRAME_W + 2;        // reciprocal width
  localparam int PW = FRAME_W + RW;       // operand times reciprocal
  localparam int MW = FRAME_W + IW + 1;   // quotient times depth
  localparam int SH = FRAME_W + IW;
  // ceil(2^SH / depth) gives the exact quotient for any FRAME_W-bit operand
  localparam longint RECIP = ((longint'(1) << SH) + longint'(RING_DEPTH) - 1)
                             / longint'(RING_DEPTH);
  localparam logic [PW-1:0] RECIP_P = PW'(RECIP);
  localparam logic [MW-1:0] DEPTH_M = MW'(RING_DEPTH);

  logic               s0_r;
  logic               s1_r;
  logic               done_r;
  logic [FRAME_W-1:0] n_r;
  logic [FRAME_W-1:0] k_r;
  logic [FRAME_W-1:0] qn_r;
  logic [FRAME_W-1:0] qk_r;
  logic [IW-1:0]      back_r;
  logic [IW-1:0]      fwd_r;
  logic [PW-1:0]      n_prod;
  logic [PW-1:0]      k_prod;
  logic [FRAME_W-1:0] qn_nxt;
  logic [FRAME_W-1:0] qk_nxt;
  logic [MW-1:0]      n_rem;
  logic [MW-1:0]      k_rem;

  // Quotient by reciprocal, then remainder by multiplying back.
  always_comb begin
    n_prod = {{RW{1'b0}}, n_r} * RECIP_P;
    k_prod = {{RW{1'b0}}, k_r} * RECIP_P;
    qn_nxt = FRAME_W'(n_prod >> SH);
    qk_nxt = FRAME_W'(k_prod >> SH);
    n_rem  = {{(IW+1){1'b0}}, n_r} - ({{(IW+1){1'b0}}, qn_r} * DEPTH_M);
    k_rem  = {{(IW+1){1'b0}}, k_r} - ({{(IW+1){1'b0}}, qk_r} * DEPTH_M);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r   <= 1'b0;
      s1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s0_r   <= start;
      s1_r   <= s0_r;
      done_r <= s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r <= frame_length;
      k_r <= FRAME_W'(position);
    end
    if (s0_r) begin
      qn_r <= qn_nxt;
      qk_r <= qk_nxt;
    end
    if (s1_r) begin
      back_r <= n_rem[IW-1:0];
      fwd_r  <= k_rem[IW-1:0];
    end
  end

  assign done = done_r;
  assign back = back_r;
  assign fwd  = fwd_r;

endmodule

`default_nettype wire

// ----- design/conference_ring_mixer.sv -----
// N-minus-one conference mixer: top level with request sequencer and slot tables.
// Depends on crm_pkg, crm_ring_mem and crm_mod_unit.
//
// Each member slot owns a ring of RING_DEPTH signed 16-bit samples in one
// shared synchronous memory, plus a write index, a wrap mark and present,
// speaking and kind flags held in registers. A write request stores a sample
// at the slot's index and advances it; a status request sets the flags. A mix
// request first reduces frame length and position modulo the ring depth by
// reciprocal multiplication, forms the read offset, then walks the first
// min(MEMBERS,8) slots one per cycle, reading memory only for contributing
// slots, accumulating with 16-bit saturation, and loads the result register
// in ST_DONE once the last sample is accumulated and the output is free.
// Slots are walked in turn through the single memory read port. A new
// request is taken only once the result register is loaded, so a stalled
// receiver holding an earlier result also holds off the next request. Ring
// entries never written since reset read as zero: the wrap mark and write
// index act as a fill count per slot, so no clearing pass runs after reset.
// Requests with func 3 or a slot at or above MEMBERS are dropped. A finished
// result waits in the output register while the next request is taken.
`default_nettype none

module conference_ring_mixer
  import crm_pkg::*;
#(
  parameter int MEMBERS    = 8,
  parameter int RING_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [2:0] slot, [18:3] sample_in, [29:19] frame_length, [39:30] position,
  // [40] speaking, [42:41] member_kind, [43] present, [47:44] zero
  input  wire logic [47:0] in_tdata,
  // [1:0] func
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [15:0] mixed_sample, [18:16] contributors, [23:19] zero
  output logic [23:0]      out_tdata,
  // last_of_frame
  output logic             out_tlast
);

  localparam int NSLOT = (MEMBERS < MAX_SLOTS) ? MEMBERS : MAX_SLOTS;
  localparam int ASW   = $clog2(NSLOT);
  localparam int IW    = $clog2(RING_DEPTH);
  localparam logic [IW:0]     DEPTH_W   = (IW+1)'(RING_DEPTH);
  localparam logic [SLOT_W:0] NSLOT_W   = (SLOT_W+1)'(NSLOT);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NSLOT - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_OFFS,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Request fields
  func_t                 in_func;
  logic [SLOT_W-1:0]     in_slot;
  logic [SAMPLE_W-1:0]   in_sample;
  logic [FRAME_W-1:0]    in_frame_length;
  logic [POS_W-1:0]      in_position;
  logic                  in_speaking;
  logic [KIND_W-1:0]     in_member_kind;
  logic                  in_present;

  assign in_func         = func_t'(in_tuser);
  assign in_slot         = in_tdata[2:0];
  assign in_sample       = in_tdata[18:3];
  assign in_frame_length = in_tdata[29:19];
  assign in_position     = in_tdata[39:30];
  assign in_speaking     = in_tdata[40];
  assign in_member_kind  = in_tdata[42:41];
  assign in_present      = in_tdata[43];

  state_t state_r;

  // Slot tables
  logic [IW-1:0]     wi_r   [MAX_SLOTS];
  logic              wrap_r [MAX_SLOTS];
  logic              spk_r  [MAX_SLOTS];
  logic [KIND_W-1:0] kind_r [MAX_SLOTS];
  logic              pres_r [MAX_SLOTS];

  // Mix context
  logic [SLOT_W-1:0]   lis_r;
  logic                master_r;
  logic                last_r;
  logic [SLOT_W-1:0]   m_r;
  logic [IW-1:0]       off_r;
  logic                p1_r;
  logic                p1_zero_r;
  logic [SAMPLE_W-1:0] acc_r;
  logic [COUNT_W-1:0]  cnt_r;

  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_sample_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic                out_last_r;

  logic                req_acc;
  logic                slot_ok;
  logic                mix_start;
  logic [SLOT_W-1:0]   rd_slot;
  logic [IW-1:0]       wi_sel;
  logic [IW-1:0]       wi_inc;
  logic                wi_wraps;
  logic                mem_we;
  logic [ASW+IW-1:0]   mem_waddr;
  logic                mem_re;
  logic [ASW+IW-1:0]   mem_raddr;
  logic [SAMPLE_W-1:0] mem_rdata;
  logic [IW:0]         pos_t;
  logic [IW-1:0]       pos;
  logic                contrib;
  logic                entry_ok;
  logic [IW:0]         off_t;
  logic [IW-1:0]       off_c;
  logic                mod_done;
  logic [IW-1:0]       mod_back;
  logic [IW-1:0]       mod_fwd;
  logic [SAMPLE_W-1:0] add_in;
  logic [SAMPLE_W:0]   sum_t;
  logic [SAMPLE_W-1:0] sum_sat;
  logic                out_free;

  assign in_tready = (state_r == ST_IDLE);
  assign req_acc   = in_tvalid && in_tready;
  assign slot_ok   = ({1'b0, in_slot} < NSLOT_W);
  assign mix_start = req_acc && slot_ok && (in_func == FUNC_MIX);

  // One read of the index table, shared by write requests and the slot walk.
  assign rd_slot  = (state_r == ST_IDLE) ? in_slot : m_r;
  assign wi_sel   = wi_r[rd_slot];
  assign wi_wraps = ({1'b0, wi_sel} + 1'b1) == DEPTH_W;
  assign wi_inc   = wi_wraps ? '0 : IW'(wi_sel + 1'b1);

  assign mem_we    = req_acc && slot_ok && (in_func == FUNC_WRITE);
  assign mem_waddr = {in_slot[ASW-1:0], wi_sel};

  // Offset back by the frame and forward by the position; both below depth.
  always_comb begin
    off_t = DEPTH_W - {1'b0, mod_back} + {1'b0, mod_fwd};
    off_c = (off_t >= DEPTH_W) ? IW'(off_t - DEPTH_W) : off_t[IW-1:0];
  end

  // Read position of the walked slot, and whether that entry was ever written.
  always_comb begin
    pos_t    = {1'b0, wi_sel} + {1'b0, off_r};
    pos      = (pos_t >= DEPTH_W) ? IW'(pos_t - DEPTH_W) : pos_t[IW-1:0];
    entry_ok = wrap_r[m_r] || (pos < wi_sel);
    contrib  = pres_r[m_r] && spk_r[m_r] && (m_r != lis_r)
               && !((kind_r[m_r] == KIND_CONSULTANT) && !master_r);
  end

  assign mem_re    = (state_r == ST_WALK) && contrib && entry_ok;
  assign mem_raddr = {m_r[ASW-1:0], pos};

  // Saturating add of the sample that came back from the ring.
  always_comb begin
    add_in = p1_zero_r ? '0 : mem_rdata;
    sum_t  = {acc_r[SAMPLE_W-1], acc_r} + {add_in[SAMPLE_W-1], add_in};
    if (sum_t[SAMPLE_W] != sum_t[SAMPLE_W-1]) begin
      sum_sat = sum_t[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      sum_sat = sum_t[SAMPLE_W-1:0];
    end
  end

  assign out_free = !out_valid_r || out_tready;

  crm_ring_mem #(
    .ADDR_W (ASW + IW)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_sample),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  crm_mod_unit #(
    .RING_DEPTH (RING_DEPTH)
  ) u_mod (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (mix_start),
    .frame_length (in_frame_length),
    .position     (in_position),
    .done         (mod_done),
    .back         (mod_back),
    .fwd          (mod_fwd)
  );

  // Slot tables: index advance on writes, flags on status requests.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        wi_r[i]   <= '0;
        wrap_r[i] <= 1'b0;
        spk_r[i]  <= 1'b0;
        kind_r[i] <= '0;
        pres_r[i] <= 1'b0;
      end
    end else if (req_acc && slot_ok) begin
      if (in_func == FUNC_WRITE) begin
        wi_r[in_slot] <= wi_inc;
        if (wi_wraps) begin
          wrap_r[in_slot] <= 1'b1;
        end
      end else if (in_func == FUNC_STATUS) begin
        spk_r[in_slot]  <= in_speaking;
        kind_r[in_slot] <= in_member_kind;
        pres_r[in_slot] <= in_present;
      end
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      p1_r        <= 1'b0;
      m_r         <= '0;
      cnt_r       <= '0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      p1_r <= (state_r == ST_WALK) && contrib;
      if (p1_r) begin
        acc_r <= sum_sat;
        if (cnt_r != '1) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      unique case (state_r)
        ST_IDLE: begin
          if (mix_start) begin
            state_r  <= ST_MOD;
            lis_r    <= in_slot;
            master_r <= (kind_r[in_slot] == KIND_MASTER);
            last_r   <= ((FRAME_W'(in_position) + 1'b1) == in_frame_length);
            acc_r    <= '0;
            cnt_r    <= '0;
          end
        end
        ST_MOD: begin
          if (mod_done) begin
            state_r <= ST_OFFS;
          end
        end
        ST_OFFS: begin
          off_r   <= off_c;
          m_r     <= '0;
          state_r <= ST_WALK;
        end
        ST_WALK: begin
          p1_zero_r <= !entry_ok;
          m_r       <= m_r + 1'b1;
          if (m_r == LAST_SLOT) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_sample_r <= acc_r;
            out_count_r  <= cnt_r;
            out_last_r   <= last_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_count_r, out_sample_r};
  assign out_tlast  = out_last_r;

  // A new result only ever follows the end of a slot walk.
  a_result_from_walk : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_DONE))
    else $error("result raised outside a completed mix");

  // Walk read positions stay inside the slot's ring.
  a_pos_in_ring : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> ({1'b0, pos} < DEPTH_W))
    else $error("ring read position beyond depth");

  // No sample may still be in flight once the block takes requests again.
  a_no_pending_add : assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !p1_r)
    else $error("accumulation pending while idle");

  // The listener never counts itself, so at most NSLOT-1 contributors.
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, out_count_r} < (COUNT_W+1)'(NSLOT)))
    else $error("contributor count exceeds other slots");

endmodule

`default_nettype wire
